// ===== src/pf_enc_pkg.sv =====
// Shared types, constants and the key square lookup for the Playfair encryptor.
package pf_enc_pkg;

   localparam int LETTER_W = 5;
   localparam int SQ_N     = 5;
   localparam int IDX_W    = 3;
   localparam int ROW_W    = SQ_N * LETTER_W;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;

   // register indexes on the csr port
   localparam logic [2:0] CSR_KEY_ROW_0 = 3'd0;
   localparam logic [2:0] CSR_KEY_ROW_4 = 3'd4;
   localparam logic [2:0] CSR_PAD       = 3'd5;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [IDX_W-1:0]    idx_type;

   // [row][column][bit]; a row register maps straight onto one row
   typedef logic [SQ_N-1:0][SQ_N-1:0][LETTER_W-1:0] pf_square_type;

   // MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC
   localparam pf_square_type KEY_RESET = {25'd2149955, 25'd6848868, 25'd25942713,
                                          25'd17283508, 25'd10755244};
   localparam letter_type PAD_RESET = 5'd23;

   // one digraph to encrypt; twice = emit it two times (repeat followed by end mark)
   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       twice;
   } pf_pair_type;

   typedef struct packed {
      logic        valid;
      pf_pair_type pair;
   } pf_push_type;

   typedef struct packed {
      idx_type row;
      idx_type col;
   } pf_pos_type;

   function automatic idx_type pf_inc(input idx_type v);
      pf_inc = (v == idx_type'(SQ_N - 1)) ? '0 : idx_type'(v + 1'b1);
   endfunction

   // first match in row-major order; absent letters land on row 0, column 0
   function automatic pf_pos_type pf_locate(input pf_square_type sq, input letter_type ch);
      letter_type key;
      pf_pos_type pos;
      key = (ch == CODE_J) ? CODE_I : ch;
      pos = '0;
      for (int r = SQ_N - 1; r >= 0; r--) begin
         for (int c = SQ_N - 1; c >= 0; c--) begin
            if (sq[r][c] == key) begin
               pos.row = idx_type'(r);
               pos.col = idx_type'(c);
            end
         end
      end
      pf_locate = pos;
   endfunction

endpackage

// ===== src/pf_enc_front.sv =====
// Front end: takes plaintext items, tracks the pending letter and queues digraphs.
module pf_enc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [4:0] letter, [7:5] zero
   input  logic                   req_tlast,   // end_of_message
   input  pf_enc_pkg::letter_type pad_letter,
   input  logic                   queue_ready,
   output pf_enc_pkg::pf_push_type push,
   output logic                   held_valid
);
   import pf_enc_pkg::*;

   letter_type held_letter_ff, held_letter_in;
   logic       held_valid_ff, held_valid_in;
   letter_type letter;
   logic       accept;

   assign letter     = req_tdata[LETTER_W-1:0];
   assign req_tready = queue_ready;
   assign accept     = req_tvalid & queue_ready;
   assign held_valid = held_valid_ff;

   always_comb begin
      held_letter_in = held_letter_ff;
      held_valid_in  = held_valid_ff;
      push           = '0;
      if (accept) begin
         if (!held_valid_ff) begin
            if (req_tlast) begin
               push.valid = 1'b1;
               push.pair  = '{first: letter, second: pad_letter, twice: 1'b0};
            end else begin
               held_letter_in = letter;
               held_valid_in  = 1'b1;
            end
         end else if (held_letter_ff != letter) begin
            push.valid    = 1'b1;
            push.pair     = '{first: held_letter_ff, second: letter, twice: 1'b0};
            held_valid_in = 1'b0;
         end else begin
            // repeat: both pairs are (letter, pad) when the end mark comes too
            push.valid     = 1'b1;
            push.pair      = '{first: held_letter_ff, second: pad_letter, twice: req_tlast};
            held_letter_in = letter;
            held_valid_in  = ~req_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_letter_ff <= '0;
         held_valid_ff  <= 1'b0;
      end else begin
         held_letter_ff <= held_letter_in;
         held_valid_ff  <= held_valid_in;
      end
   end

endmodule

// ===== src/pf_enc_fifo.sv =====
// Small digraph queue between front and back ends.
module pf_enc_fifo #(
   parameter int DEPTH = pf_enc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pf_enc_pkg::pf_push_type push,
   output logic                    ready,
   output logic                    head_valid,
   output pf_enc_pkg::pf_pair_type head,
   input  logic                    pop,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   import pf_enc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pf_pair_type       slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign ready      = (count_ff != CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign level      = count_ff;
   assign do_push    = push.valid & ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = CW'(count_ff + 1'b1);
         2'b01:   count_in = CW'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.pair;
      end
   end

endmodule

// ===== src/pf_enc_back.sv =====
// Back end: encrypts one digraph against the key square and emits its letters.
module pf_enc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pf_enc_pkg::pf_square_type square,
   input  logic                      head_valid,
   input  pf_enc_pkg::pf_pair_type   head,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // [4:0] cipher_letter, [7:5] zero
   output logic                      rsp_tlast   // last_of_run
);
   import pf_enc_pkg::*;

   letter_type x_ff, x_in, y_ff, y_in;
   logic [2:0] rem_ff, rem_in;   // letters still to send, 0..4
   pf_pos_type p1, p2;
   logic       take;

   always_comb begin
      p1 = pf_locate(square, head.first);
      p2 = pf_locate(square, head.second);
      if (p1.row == p2.row) begin
         x_in = square[p1.row][pf_inc(p1.col)];
         y_in = square[p2.row][pf_inc(p2.col)];
      end else if (p1.col == p2.col) begin
         x_in = square[pf_inc(p1.row)][p1.col];
         y_in = square[pf_inc(p2.row)][p2.col];
      end else begin
         x_in = square[p1.row][p2.col];
         y_in = square[p2.row][p1.col];
      end
   end

   assign take = rsp_tvalid & rsp_tready;
   assign pop  = head_valid & ((rem_ff == 3'd0) | ((rem_ff == 3'd1) & rsp_tready));

   always_comb begin
      rem_in = rem_ff;
      if (pop) begin
         rem_in = head.twice ? 3'd4 : 3'd2;
      end else if (take) begin
         rem_in = 3'(rem_ff - 1'b1);
      end
   end

   assign rsp_tvalid = (rem_ff != 3'd0);
   assign rsp_tlast  = (rem_ff == 3'd1);
   assign rsp_tdata  = {3'b000, rem_ff[0] ? y_ff : x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

endmodule

// ===== src/playfair_encryptor_core.sv =====
// Top level of the Playfair encryptor: key registers, front end, queue, back end.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  req     | in  | req_tvalid/tready  | tdata[4:0] letter, tlast end_of_message
//  rsp     | out | rsp_tvalid/tready  | tdata[4:0] cipher_letter, tlast last_of_run
//  csr     | in  | csr_valid/ready    | csr_index 0..4 key rows, 5 pad; csr_wdata
//
// An item is taken every cycle while the digraph queue has room; items that only
// set the pending letter touch nothing downstream.
// Each digraph leaves the back end as two result items, four for a repeated
// letter closing a message; the output stage sets the rate.
// A new digraph is loaded as its predecessor's last letter is taken, so the
// output runs without gaps while digraphs are queued. Synchronous reset restores
// the default square (MFHIK/UNOPQ/ZVWXY/ELARG/DSTBC), pad X and an empty pending slot.
// rsp_tready low stalls only the back end; the front keeps going until the queue fills.
module playfair_encryptor_core #(
   parameter int QUEUE_DEPTH = pf_enc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] letter, [7:5] zero
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] cipher_letter, [7:5] zero
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import pf_enc_pkg::*;

   pf_square_type square_ff;
   letter_type    pad_ff;
   pf_push_type   push;
   pf_pair_type   head;
   logic          queue_ready, head_valid, pop, held_valid;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

   // csr writes are always taken; software is to write only while the core is idle, which the core does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= KEY_RESET;
         pad_ff    <= PAD_RESET;
      end else if (csr_valid) begin
         if (csr_index <= CSR_KEY_ROW_4) begin
            square_ff[csr_index] <= csr_wdata;
         end else if (csr_index == CSR_PAD) begin
            pad_ff <= csr_wdata[LETTER_W-1:0];
         end
      end
   end

   pf_enc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .pad_letter  (pad_ff),
      .queue_ready (queue_ready),
      .push        (push),
      .held_valid  (held_valid)
   );

   pf_enc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .ready      (queue_ready),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .level      (level)
   );

   pf_enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .square     (square_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // an end mark always leaves nothing pending
   a_eom_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !held_valid)
      else $error("pending letter survived end of message");

   // a letter arriving with nothing pending and no end mark produces no digraph
   a_first_no_push: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast && !held_valid) |-> !push.valid)
      else $error("digraph queued for a lone first letter");

   // queue level stays within its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("digraph queue overflow");

   // a digraph is only loaded once the previous one has been fully sent
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_tvalid || (rsp_tlast && rsp_tready)))
      else $error("digraph loaded over unsent letters");

endmodule
